// ===== hdl/svi_pkg.sv =====
// ----------------------------------------------------------------------------
// svi_pkg
// Shared constants and types for the settling velocity iteration block.
// ----------------------------------------------------------------------------
package svi_pkg;

  localparam int FRAC_BITS = 24;
  localparam int TOL_BITS  = 24;

  localparam logic [63:0] ONE_P4_Q32 = 64'd6012954214;
  localparam logic [63:0] ALL_ONES   = {64{1'b1}};

  localparam logic [2:0] REG_VISCOSITY = 3'd0;
  localparam logic [2:0] REG_GRAVITY   = 3'd1;
  localparam logic [2:0] REG_TOLERANCE = 3'd2;
  localparam logic [2:0] REG_LIMIT     = 3'd3;
  localparam logic [2:0] REG_GUESS     = 3'd4;

  localparam logic [1:0] ST_CONVERGED = 2'd0;
  localparam logic [1:0] ST_LIMIT     = 2'd1;
  localparam logic [1:0] ST_INVALID   = 2'd2;

  typedef struct packed {
    logic        start;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] den;
  } div_req_t;

endpackage

// ===== hdl/svi_div.sv =====
// ----------------------------------------------------------------------------
// svi_div
// Restoring divider, 128 by 64 bits, one quotient bit per cycle, saturated.
// ----------------------------------------------------------------------------
module svi_div import svi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  div_req_t    req,
  output logic        done,
  output logic [63:0] quot
);

  logic        busy;
  logic [5:0]  cnt;
  logic [63:0] rem;
  logic [63:0] lo_sh;
  logic [63:0] den;
  logic [63:0] sh;
  logic        carry;
  logic        take;

  assign carry = rem[63];
  assign sh    = {rem[62:0], lo_sh[63]};
  assign take  = carry || (sh >= den);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        den <= req.den;
        if (req.hi >= req.den) begin
          quot <= ALL_ONES;
          done <= 1'b1;
        end else begin
          rem   <= req.hi;
          lo_sh <= req.lo;
          quot  <= '0;
          cnt   <= '0;
          busy  <= 1'b1;
        end
      end else if (busy) begin
        lo_sh <= {lo_sh[62:0], 1'b0};
        if (take) begin
          rem  <= sh - den;
          quot <= {quot[62:0], 1'b1};
        end else begin
          rem  <= sh;
          quot <= {quot[62:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/svi_sqrt.sv =====
// ----------------------------------------------------------------------------
// svi_sqrt
// Integer square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module svi_sqrt import svi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] x_in,
  output logic        done,
  output logic [31:0] root
);

  logic        busy;
  logic [4:0]  k;
  logic [63:0] x;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [63:0] rb;

  assign bitv = 64'd1 << {k, 1'b0};
  assign rb   = res + bitv;
  assign root = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      k    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x    <= x_in;
        res  <= '0;
        k    <= 5'd31;
        busy <= 1'b1;
      end else if (busy) begin
        if (x >= rb) begin
          x   <= x - rb;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        k <= k - 5'd1;
        if (k == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/settling_velocity_iteration_top.sv =====
// ----------------------------------------------------------------------------
// settling_velocity_iteration_top
// Grain settling velocity by fixed-point iteration on a shared datapath.
// ----------------------------------------------------------------------------
// One item is taken at a time; s_tready is high only while the block is idle.
// Setup runs one 64-step division and five multiplies, and each velocity
// update runs up to two 64-step divisions and a 32-step square root on the
// shared divider and root units, plus multiplies and a compare. An item with
// n iterations runs n + 1 updates; items with invalid densities go straight
// to the output state.
module settling_velocity_iteration_top import svi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [47:0] wr_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // diameter, solid_density, fluid_density
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // velocity, iterations, status, zero pad
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_GD      = 5'd1;
  localparam logic [4:0] S_A_START = 5'd2;
  localparam logic [4:0] S_A_WAIT  = 5'd3;
  localparam logic [4:0] S_M0      = 5'd4;
  localparam logic [4:0] S_M1      = 5'd5;
  localparam logic [4:0] S_M2      = 5'd6;
  localparam logic [4:0] S_M3      = 5'd7;
  localparam logic [4:0] S_M4      = 5'd8;
  localparam logic [4:0] S_FP      = 5'd9;
  localparam logic [4:0] S_FT      = 5'd10;
  localparam logic [4:0] S_FT_WAIT = 5'd11;
  localparam logic [4:0] S_FV      = 5'd12;
  localparam logic [4:0] S_FV_WAIT = 5'd13;
  localparam logic [4:0] S_FS_WAIT = 5'd14;
  localparam logic [4:0] S_TOL     = 5'd15;
  localparam logic [4:0] S_CONV    = 5'd16;
  localparam logic [4:0] S_CHK     = 5'd17;
  localparam logic [4:0] S_DONE    = 5'd18;

  localparam int A_SH = FRAC_BITS + 2;
  localparam int T_SH = FRAC_BITS + 16;

  logic [47:0] viscosity;
  logic [31:0] gravity;
  logic [23:0] tolerance;
  logic [9:0]  iteration_limit;
  logic [31:0] initial_guess;

  logic [4:0]   state;
  logic [31:0]  diam;
  logic [31:0]  rs;
  logic [31:0]  rf;
  logic [63:0]  a;
  logic [63:0]  gd;
  logic [127:0] m;
  logic [63:0]  c;
  logic [31:0]  wcur;
  logic [31:0]  w1;
  logic [9:0]   count;
  logic         conv;
  logic         first;
  logic [1:0]   status;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;

  div_req_t    dreq;
  logic        ddone;
  logic [63:0] dq;
  logic        sq_start;
  logic        sq_done;
  logic [31:0] sq_root;

  logic [53:0]  nu36;
  logic [127:0] t_num;
  logic [127:0] a_num;
  logic [64:0]  c_sum;
  logic [31:0]  diff;
  logic [31:0]  in_diam;
  logic [31:0]  in_rs;
  logic [31:0]  in_rf;

  assign in_diam = s_tdata[31:0];
  assign in_rs   = s_tdata[63:32];
  assign in_rf   = s_tdata[95:64];

  assign nu36  = {viscosity, 5'b0} + {2'b0, viscosity, 2'b0} + 54'd0;
  assign t_num = {74'b0, nu36} << T_SH;
  assign a_num = {96'b0, rs - rf} << A_SH;
  assign c_sum = {1'b0, dq} + {1'b0, ONE_P4_Q32};
  assign diff  = (wcur > w1) ? (wcur - w1) : (w1 - wcur);

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      viscosity       <= 48'd281474977;
      gravity         <= 32'd164584489;
      tolerance       <= 24'd16777;
      iteration_limit <= 10'd1000;
      initial_guess   <= 32'd1677722;
    end else if (wr_en) begin
      case (wr_index)
        REG_VISCOSITY: viscosity       <= wr_data;
        REG_GRAVITY:   gravity         <= wr_data[31:0];
        REG_TOLERANCE: tolerance       <= wr_data[23:0];
        REG_LIMIT:     iteration_limit <= wr_data[9:0];
        REG_GUESS:     initial_guess   <= wr_data[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_GD:   begin mul_a = gravity;   mul_b = diam;       end
      S_M0:   begin mul_a = a[31:0];   mul_b = gd[31:0];   end
      S_M1:   begin mul_a = a[31:0];   mul_b = gd[63:32];  end
      S_M2:   begin mul_a = a[63:32];  mul_b = gd[31:0];   end
      S_M3:   begin mul_a = a[63:32];  mul_b = gd[63:32];  end
      S_FP:   begin mul_a = wcur;      mul_b = diam;       end
      S_TOL:  begin mul_a = {8'b0, tolerance}; mul_b = w1; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_comb begin
    dreq = '0;
    case (state)
      S_A_START: begin
        dreq.start = 1'b1;
        dreq.hi    = a_num[127:64];
        dreq.lo    = a_num[63:0];
        dreq.den   = {30'b0, {2'b0, rf} + {1'b0, rf, 1'b0}};
      end
      S_FT: begin
        dreq.start = (prod != 64'd0);
        dreq.hi    = t_num[127:64];
        dreq.lo    = t_num[63:0];
        dreq.den   = prod;
      end
      S_FV: begin
        dreq.start = 1'b1;
        dreq.hi    = m[127:64];
        dreq.lo    = m[63:0];
        dreq.den   = c;
      end
      default: ;
    endcase
  end

  assign sq_start = (state == S_FV_WAIT) && ddone;

  svi_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (dreq),
    .done (ddone),
    .quot (dq)
  );

  svi_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .x_in  (dq),
    .done  (sq_done),
    .root  (sq_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      count    <= '0;
      conv     <= 1'b0;
      first    <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            diam  <= in_diam;
            rs    <= in_rs;
            rf    <= in_rf;
            count <= '0;
            conv  <= 1'b0;
            first <= 1'b1;
            if (in_rf == 32'd0 || in_rs <= in_rf) begin
              w1     <= '0;
              status <= ST_INVALID;
              state  <= S_DONE;
            end else begin
              state <= S_GD;
            end
          end
        end
        S_GD:      state <= S_A_START;
        S_A_START: begin
          gd    <= prod;
          state <= S_A_WAIT;
        end
        S_A_WAIT: begin
          if (ddone) begin
            a     <= dq;
            state <= S_M0;
          end
        end
        S_M0: state <= S_M1;
        S_M1: begin
          m     <= {64'b0, prod};
          state <= S_M2;
        end
        S_M2: begin
          m     <= m + {32'b0, prod, 32'b0};
          state <= S_M3;
        end
        S_M3: begin
          m     <= m + {32'b0, prod, 32'b0};
          state <= S_M4;
        end
        S_M4: begin
          m     <= m + {prod, 64'b0};
          wcur  <= initial_guess;
          state <= S_FP;
        end
        S_FP: state <= S_FT;
        S_FT: begin
          if (prod == 64'd0) begin
            c     <= ALL_ONES;
            state <= S_FV;
          end else begin
            state <= S_FT_WAIT;
          end
        end
        S_FT_WAIT: begin
          if (ddone) begin
            c     <= c_sum[64] ? ALL_ONES : c_sum[63:0];
            state <= S_FV;
          end
        end
        S_FV: state <= S_FV_WAIT;
        S_FV_WAIT: begin
          if (ddone) begin
            state <= S_FS_WAIT;
          end
        end
        S_FS_WAIT: begin
          if (sq_done) begin
            w1 <= sq_root;
            if (first) begin
              first <= 1'b0;
              state <= S_CHK;
            end else begin
              state <= S_TOL;
            end
          end
        end
        S_TOL: state <= S_CONV;
        S_CONV: begin
          conv  <= ({8'b0, diff, 24'b0} <= prod);
          state <= S_CHK;
        end
        S_CHK: begin
          if (count < iteration_limit && !conv) begin
            count <= count + 10'd1;
            wcur  <= w1;
            state <= S_FP;
          end else begin
            status <= (count >= iteration_limit) ? ST_LIMIT : ST_CONVERGED;
            state  <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {4'b0, status, count, w1};
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
